### sv/assert_macros.svh
// Assertion helpers for the timer table RTL.
// HBT_ASSERT checks that a property holds on every rising clock edge out of reset.
// HBT_NEVER checks that a condition is never seen on a rising clock edge out of reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HBT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define HBT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define HBT_ASSERT(lbl, clk, rst, prop)
`define HBT_NEVER(lbl, clk, rst, cond)

`endif

`endif

### sv/hbt_pkg.sv
`default_nettype none

package hbt_pkg;

  // Countdown and reload width, and width of the requested interval
  localparam int CNT_W = 15;
  localparam int IVL_W = 16;

  // Input operations
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_TICK = 2'd1,
    OP_GONE = 2'd2
  } op_t;

  // Result status codes
  localparam logic [2:0] ST_FIRED    = 3'd0;
  localparam logic [2:0] ST_NONE     = 3'd1;
  localparam logic [2:0] ST_ENABLED  = 3'd2;
  localparam logic [2:0] ST_UPDATED  = 3'd3;
  localparam logic [2:0] ST_DISABLED = 3'd4;
  localparam logic [2:0] ST_REJECTED = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;
  localparam logic [2:0] ST_GONE     = 3'd7;

  // Request packet walking down the row of cells
  typedef struct packed {
    logic             valid;
    logic             gone;      // object-gone request, otherwise a set request
    logic             found;     // an earlier cell held the object
    logic             appended;  // an earlier cell took a new entry
    logic             removing;  // later cells pull their right neighbour in
    logic [IVL_W-1:0] interval;
  } pkt_t;

endpackage

`default_nettype wire

### sv/hbt_cell.sv
`default_nettype none

module hbt_cell
  import hbt_pkg::*;
#(
  parameter int OBJ_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick,
  input  logic             shift,
  input  pkt_t             pin,
  input  logic [OBJ_W-1:0] pin_obj,
  output pkt_t             pout,
  output logic [OBJ_W-1:0] pout_obj,
  input  logic             nb_valid,
  input  logic [OBJ_W-1:0] nb_object,
  input  logic [CNT_W-1:0] nb_reload,
  input  logic [CNT_W-1:0] nb_count,
  input  logic             nb_fire,
  input  logic [OBJ_W-1:0] nb_rep_obj,
  output logic             valid,
  output logic [OBJ_W-1:0] object,
  output logic [CNT_W-1:0] reload,
  output logic [CNT_W-1:0] count,
  output logic             rep_fire,
  output logic [OBJ_W-1:0] rep_obj
);

  logic             valid_next;
  logic [OBJ_W-1:0] object_next;
  logic [CNT_W-1:0] reload_next;
  logic [CNT_W-1:0] count_next;
  logic             rep_fire_next;
  logic [OBJ_W-1:0] rep_obj_next;
  pkt_t             pout_next;
  logic             match;
  logic             neg;
  logic             zero;
  logic [CNT_W-1:0] ival;
  logic [CNT_W-1:0] newval;
  logic             due;

  assign match  = valid && (object == pin_obj);
  assign neg    = pin.interval[IVL_W-1];
  assign zero   = (pin.interval == '0);
  assign ival   = pin.interval[CNT_W-1:0];
  assign newval = neg ? CNT_W'(1) : ival;
  assign due    = (count <= CNT_W'(1));

  // Act on a passing request, or count down on a tick, reloading when due
  always_comb begin
    valid_next  = valid;
    object_next = object;
    reload_next = reload;
    count_next  = count;
    pout_next   = pin;
    if (pin.valid) begin
      if (pin.removing) begin
        valid_next  = nb_valid;
        object_next = nb_object;
        reload_next = nb_reload;
        count_next  = nb_count;
      end else if (match) begin
        pout_next.found = 1'b1;
        if (pin.gone || zero) begin
          valid_next         = nb_valid;
          object_next        = nb_object;
          reload_next        = nb_reload;
          count_next         = nb_count;
          pout_next.removing = 1'b1;
        end else if (!neg) begin
          reload_next = ival;
          count_next  = ival;
        end
      end else if (!valid && !pin.found && !pin.appended && !pin.gone && !zero) begin
        valid_next         = 1'b1;
        object_next        = pin_obj;
        reload_next        = newval;
        count_next         = newval;
        pout_next.appended = 1'b1;
      end
    end else if (tick && valid) begin
      count_next = due ? reload : count - CNT_W'(1);
    end
  end

  // Load the firing report on a tick, then pass reports towards the head
  always_comb begin
    rep_fire_next = rep_fire;
    rep_obj_next  = rep_obj;
    if (tick) begin
      rep_fire_next = valid && due;
      rep_obj_next  = object;
    end else if (shift) begin
      rep_fire_next = nb_fire;
      rep_obj_next  = nb_rep_obj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      rep_fire <= 1'b0;
      pout     <= '0;
    end else begin
      valid    <= valid_next;
      rep_fire <= rep_fire_next;
      pout     <= pout_next;
    end
  end

  // Hold entry payload and the request object
  always_ff @(posedge clk) begin
    object   <= object_next;
    reload   <= reload_next;
    count    <= count_next;
    rep_obj  <= rep_obj_next;
    pout_obj <= pin_obj;
  end

endmodule

`default_nettype wire

### sv/heartbeat_timer_table_core.sv
// Set and object-gone requests walk the row of ENTRIES cells one cell per cycle;
// the single result is captured in S_WAVE and offered from S_FINISH.
// A tick counts down every cell in the same cycle, then the firing reports drain
// from the head of the row, one shift per entry, one result per cycle at most.
// One item is in work at a time: a new word is taken only after the last result is offered.
// Reset clears the valid bits, the sequencer and the output; entry payload is not reset.
`default_nettype none
`include "assert_macros.svh"

module heartbeat_timer_table_core
  import hbt_pkg::*;
#(
  parameter int ENTRIES        = 16,
  parameter int OBJECT_ID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // opcode[1:0], object_id[9:2], interval[25:10]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_object[7:0]
  output logic [2:0]  m_tuser,  // status[2:0]
  output logic        m_tlast   // last_result
);

  localparam int OBJ_W = OBJECT_ID_BITS;
  localparam int CW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAVE,
    S_FINISH,
    S_DRAIN,
    S_CLOSE
  } state_t;

  state_t           state, state_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic             hvalid, hvalid_next;
  logic [OBJ_W-1:0] hobj, hobj_next;
  logic [OBJ_W-1:0] fin_obj, fin_obj_next;
  logic [2:0]       fin_status, fin_status_next;
  logic             m_tvalid_next;
  logic [7:0]       m_tdata_next;
  logic [2:0]       m_tuser_next;
  logic             m_tlast_next;

  logic             out_free;
  logic             tick;
  logic             shift;
  op_t              op;
  pkt_t             launch;
  logic [OBJ_W-1:0] launch_obj;
  pkt_t             end_pkt;
  logic [OBJ_W-1:0] end_obj;
  logic             step_ok;

  // Row of cells
  pkt_t             pin_a      [ENTRIES];
  logic [OBJ_W-1:0] pin_obj_a  [ENTRIES];
  pkt_t             pkt_a      [ENTRIES];
  logic [OBJ_W-1:0] pobj_a     [ENTRIES];
  logic             valid_a    [ENTRIES];
  logic [OBJ_W-1:0] object_a   [ENTRIES];
  logic [CNT_W-1:0] reload_a   [ENTRIES];
  logic [CNT_W-1:0] count_a    [ENTRIES];
  logic             fire_a     [ENTRIES];
  logic [OBJ_W-1:0] rep_obj_a  [ENTRIES];
  logic             nb_valid_a [ENTRIES];
  logic [OBJ_W-1:0] nb_obj_a   [ENTRIES];
  logic [CNT_W-1:0] nb_rel_a   [ENTRIES];
  logic [CNT_W-1:0] nb_cnt_a   [ENTRIES];
  logic             nb_fire_a  [ENTRIES];
  logic [OBJ_W-1:0] nb_rep_a   [ENTRIES];
  logic [ENTRIES-1:0] pv;
  logic [ENTRIES-1:0] vv;
  logic [ENTRIES:0]   vv_inc;

  assign op         = op_t'(s_tdata[1:0]);
  assign launch_obj = OBJ_W'(s_tdata[9:2]);
  assign s_tready   = (state == S_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign end_pkt    = pkt_a[ENTRIES-1];
  assign end_obj    = pobj_a[ENTRIES-1];
  assign step_ok    = !(fire_a[0] && hvalid) || out_free;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    // Feed the first cell from the input, the others from their left neighbour
    if (i == 0) begin : g_head
      assign pin_a[i]     = launch;
      assign pin_obj_a[i] = launch_obj;
    end else begin : g_body
      assign pin_a[i]     = pkt_a[i-1];
      assign pin_obj_a[i] = pobj_a[i-1];
    end

    // The last cell pulls in an empty entry
    if (i == ENTRIES - 1) begin : g_tail
      assign nb_valid_a[i] = 1'b0;
      assign nb_obj_a[i]   = '0;
      assign nb_rel_a[i]   = '0;
      assign nb_cnt_a[i]   = '0;
      assign nb_fire_a[i]  = 1'b0;
      assign nb_rep_a[i]   = '0;
    end else begin : g_link
      assign nb_valid_a[i] = valid_a[i+1];
      assign nb_obj_a[i]   = object_a[i+1];
      assign nb_rel_a[i]   = reload_a[i+1];
      assign nb_cnt_a[i]   = count_a[i+1];
      assign nb_fire_a[i]  = fire_a[i+1];
      assign nb_rep_a[i]   = rep_obj_a[i+1];
    end

    assign pv[i] = pkt_a[i].valid;
    assign vv[i] = valid_a[i];

    hbt_cell #(
      .OBJ_W (OBJ_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .tick       (tick),
      .shift      (shift),
      .pin        (pin_a[i]),
      .pin_obj    (pin_obj_a[i]),
      .pout       (pkt_a[i]),
      .pout_obj   (pobj_a[i]),
      .nb_valid   (nb_valid_a[i]),
      .nb_object  (nb_obj_a[i]),
      .nb_reload  (nb_rel_a[i]),
      .nb_count   (nb_cnt_a[i]),
      .nb_fire    (nb_fire_a[i]),
      .nb_rep_obj (nb_rep_a[i]),
      .valid      (valid_a[i]),
      .object     (object_a[i]),
      .reload     (reload_a[i]),
      .count      (count_a[i]),
      .rep_fire   (fire_a[i]),
      .rep_obj    (rep_obj_a[i])
    );
  end

  assign vv_inc = {1'b0, vv} + (ENTRIES + 1)'(1);

  // Sequencer: launch requests, collect the answer, drain firing reports
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    hvalid_next     = hvalid;
    hobj_next       = hobj;
    fin_obj_next    = fin_obj;
    fin_status_next = fin_status;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;
    m_tlast_next    = m_tlast;
    tick            = 1'b0;
    shift           = 1'b0;
    launch          = '0;
    launch.gone     = (op == OP_GONE);
    launch.interval = s_tdata[25:10];

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (op)
            OP_SET, OP_GONE: begin
              launch.valid = 1'b1;
              state_next   = S_WAVE;
            end
            OP_TICK: begin
              tick        = 1'b1;
              cnt_next    = '0;
              hvalid_next = 1'b0;
              state_next  = S_DRAIN;
            end
            default: ;
          endcase
        end
      end

      S_WAVE: begin
        if (end_pkt.valid) begin
          fin_obj_next = end_obj;
          if (end_pkt.gone) begin
            fin_status_next = ST_GONE;
          end else if (end_pkt.interval == '0) begin
            fin_status_next = ST_DISABLED;
          end else if (end_pkt.found) begin
            fin_status_next = end_pkt.interval[IVL_W-1] ? ST_REJECTED : ST_UPDATED;
          end else if (end_pkt.appended) begin
            fin_status_next = ST_ENABLED;
          end else begin
            fin_status_next = ST_FULL;
          end
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = 8'(fin_obj);
          m_tuser_next  = fin_status;
          m_tlast_next  = 1'b1;
          state_next    = S_IDLE;
        end
      end

      S_DRAIN: begin
        // Hold one fired object back so the final one can be flagged
        if (step_ok) begin
          shift = 1'b1;
          if (fire_a[0]) begin
            if (hvalid) begin
              m_tvalid_next = 1'b1;
              m_tdata_next  = 8'(hobj);
              m_tuser_next  = ST_FIRED;
              m_tlast_next  = 1'b0;
            end
            hvalid_next = 1'b1;
            hobj_next   = rep_obj_a[0];
          end
          cnt_next = cnt + CW'(1);
          if (cnt == CNT_LAST) begin
            state_next = S_CLOSE;
          end
        end
      end

      S_CLOSE: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = hvalid ? 8'(hobj) : 8'd0;
          m_tuser_next  = hvalid ? ST_FIRED : ST_NONE;
          m_tlast_next  = 1'b1;
          state_next    = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      hvalid   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      hvalid     <= hvalid_next;
      m_tvalid   <= m_tvalid_next;
      hobj       <= hobj_next;
      fin_obj    <= fin_obj_next;
      fin_status <= fin_status_next;
      m_tdata    <= m_tdata_next;
      m_tuser    <= m_tuser_next;
      m_tlast    <= m_tlast_next;
    end
  end

  // At most one request in the row of cells
  `HBT_ASSERT(a_one_pkt, clk, rst, $onehot0(pv))
  // A request leaves the row only while the sequencer waits for it
  `HBT_ASSERT(a_end_in_wave, clk, rst, pv[ENTRIES-1] |-> state == S_WAVE)
  // Valid entries stay packed at the start of the table
  `HBT_ASSERT(a_packed, clk, rst, $onehot(vv_inc))
  // Only fired objects come out without the last flag
  `HBT_ASSERT(a_mid_fired, clk, rst, m_tvalid && !m_tlast |-> m_tuser == ST_FIRED)
  // No word is taken while a request is still in the row
  `HBT_NEVER(a_busy_accept, clk, rst, s_tready && pv != '0)

endmodule

`default_nettype wire
